[design/grayscale_error_diffusion_dither_defines.svh]
// ----------------------------------------------------------------------------
// Dither assertion macros
// Shared concurrent assertion forms for the grayscale dither block.
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define GRAYSCALE_ERROR_DIFFUSION_DITHER_DEFINES_SVH

// same-cycle implication
`define GEDD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GEDD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/gedd_pkg.sv]
// ----------------------------------------------------------------------------
// Dither package
// Types and constants shared by the grayscale error diffusion dither modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gedd_pkg;

   localparam int MAX_HEIGHT_DEFAULT = 1024;
   localparam int MAX_WIDTH          = 4096;
   localparam int SIZE_W             = 13;
   localparam int COL_W              = 12;
   localparam int LUM_W              = 16;
   localparam int RESID_W            = 12;
   localparam int CSR_DATA_W         = 13;
   localparam int CSR_INDEX_W        = 2;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [7:0] LUM_WEIGHT_R = 8'd77;
   localparam logic [7:0] LUM_WEIGHT_G = 8'd151;
   localparam logic [7:0] LUM_WEIGHT_B = 8'd28;
   localparam logic [17:0] CLAMP_Q9    = 18'(255 * 512);

   localparam logic              RESET_COLOR_MODE   = 1'b1;
   localparam logic [SIZE_W-1:0] RESET_IMAGE_WIDTH  = SIZE_W'(800);
   localparam logic [10:0]       RESET_IMAGE_HEIGHT = 11'd600;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLOR_MODE   = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LUM_W-1:0] lum;
      logic             has_left;
      logic             has_up;
      logic             eoi;
   } pix_type;

   typedef struct packed {
      logic [7:0] gray;
      logic       eoi;
   } result_type;

endpackage

`default_nettype wire

[design/gedd_queue.sv]
// ----------------------------------------------------------------------------
// Dither queue
// Small synchronous FIFO used between the front, the back and the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gedd_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);

   localparam int Depth = gedd_pkg::QUEUE_DEPTH;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   logic [WIDTH-1:0] slot_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[design/gedd_front.sv]
// ----------------------------------------------------------------------------
// Dither front end
// Holds the size and mode registers, tracks the scan position and forms the
// luminance of each accepted pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gedd_front #(
   parameter int MAX_HEIGHT = gedd_pkg::MAX_HEIGHT_DEFAULT,
   parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [gedd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [gedd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                               accept,
   input  wire logic [7:0]                         red,
   input  wire logic [7:0]                         green,
   input  wire logic [7:0]                         blue,
   output gedd_pkg::pix_type                       pix,
   output logic      [ROW_W-1:0]                   pix_row
);

   localparam int SizeW = gedd_pkg::SIZE_W;
   localparam int LumW  = gedd_pkg::LUM_W;
   localparam int ColW  = gedd_pkg::COL_W;

   logic                 color_mode_ff;
   logic [SizeW-1:0]     image_width_ff;
   logic [10:0]          image_height_ff;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ColW-1:0]      col_ff, col_in;
   logic [SizeW-1:0]     width_eff, height_eff;
   logic                 last_row, last_col;
   logic [LumW-1:0]      lum;

   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = SizeW'(1);
      end else if (image_width_ff > SizeW'(gedd_pkg::MAX_WIDTH)) begin
         width_eff = SizeW'(gedd_pkg::MAX_WIDTH);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = SizeW'(1);
      end else if (SizeW'(image_height_ff) > SizeW'(MAX_HEIGHT)) begin
         height_eff = SizeW'(MAX_HEIGHT);
      end else begin
         height_eff = SizeW'(image_height_ff);
      end
   end

   always_comb begin
      if (color_mode_ff) begin
         lum = LumW'(red)   * LumW'(gedd_pkg::LUM_WEIGHT_R)
             + LumW'(green) * LumW'(gedd_pkg::LUM_WEIGHT_G)
             + LumW'(blue)  * LumW'(gedd_pkg::LUM_WEIGHT_B);
      end else begin
         lum = {red, 8'h00};
      end
   end

   assign last_row = (SizeW'(row_ff) + SizeW'(1)) >= height_eff;
   assign last_col = (SizeW'(col_ff) + SizeW'(1)) >= width_eff;

   always_comb begin
      pix.lum      = lum;
      pix.has_left = (col_ff != '0);
      pix.has_up   = (row_ff != '0);
      pix.eoi      = last_row && last_col;
      pix_row      = row_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (accept) begin
         if (last_row) begin
            row_in = '0;
            col_in = last_col ? '0 : col_ff + ColW'(1);
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff   <= gedd_pkg::RESET_COLOR_MODE;
         image_width_ff  <= gedd_pkg::RESET_IMAGE_WIDTH;
         image_height_ff <= gedd_pkg::RESET_IMAGE_HEIGHT;
      end else if (csr_wr_en) begin
         case (csr_index)
            gedd_pkg::CSR_COLOR_MODE:   color_mode_ff   <= csr_wdata[0];
            gedd_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            gedd_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

[design/gedd_back.sv]
// ----------------------------------------------------------------------------
// Dither back end
// Reads the row residual store, adds the carried error, clamps, quantizes and
// writes the new residual back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gedd_back #(
   parameter int MAX_HEIGHT = gedd_pkg::MAX_HEIGHT_DEFAULT,
   parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire gedd_pkg::pix_type    q_pix,
   input  wire logic [ROW_W-1:0]     q_row,
   output logic                      q_pop,
   input  wire logic                 out_full,
   output logic                      out_push,
   output gedd_pkg::result_type      out_result
);

   localparam int ResW = gedd_pkg::RESID_W;

   logic [ResW-1:0]    store_mem [MAX_HEIGHT];
   logic [ResW-1:0]    left_ff;
   logic [ResW-1:0]    up_ff;
   logic               busy_ff, busy_in;
   gedd_pkg::pix_type  pix_ff;
   logic [ROW_W-1:0]   row_ff;
   logic               load, done;
   logic [17:0]        sum;
   logic [16:0]        sum_cl;
   logic [ResW-1:0]    resid;

   assign done    = busy_ff && !out_full;
   assign load    = !q_empty && (!busy_ff || done);
   assign q_pop   = load;
   assign busy_in = load || (busy_ff && !done);

   always_comb begin
      sum = {pix_ff.lum, 1'b0}
          + (pix_ff.has_left ? 18'(left_ff) : '0)
          + (pix_ff.has_up   ? 18'(up_ff)   : '0);
      sum_cl = (sum > gedd_pkg::CLAMP_Q9) ? gedd_pkg::CLAMP_Q9[16:0] : sum[16:0];
      resid  = sum_cl[12:1];
      out_push        = done;
      out_result.gray = {sum_cl[16:13], 4'h0};
      out_result.eoi  = pix_ff.eoi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         up_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         if (done) begin
            up_ff <= resid;
         end
      end
   end

   // hold the stage payload and the row read while stalled; bypass same-row write
   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff  <= q_pix;
         row_ff  <= q_row;
         left_ff <= (done && row_ff == q_row) ? resid : store_mem[q_row];
      end
      if (done) begin
         store_mem[row_ff] <= resid;
      end
   end

endmodule

`default_nettype wire

[design/grayscale_error_diffusion_dither.sv]
// ----------------------------------------------------------------------------
// Grayscale error diffusion dither
// Sixteen-level error diffusion of a column-ordered pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel (push/full) in column order, top to bottom
// within each column; red, green and blue are taken on a transfer. Results
// leave on the rsp_ channel (empty/pop): the oldest quantized gray level and
// its end-of-image flag stand on the ports while rsp_empty is low.
// A transferred pixel passes the inner queue, the back-end stage and the
// result queue before it shows on the result ports. Throughput: one pixel
// per clock while results drain, set by the single read and single write of
// the row residual store per pixel and by the carry of the upper residual.
// The csr_ port writes one of color_mode, image_width and image_height per
// write, chosen by csr_index; write only while no pixel is in flight.
// Reset empties both queues, clears the scan position and the upper
// residual, and loads color mode, width 800 and height 600. The row store
// is not cleared: the first column never reads it.
// When the receiver stalls, results gather in a two-entry queue, the back
// end then halts, the inner queue fills and req_full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "grayscale_error_diffusion_dither_defines.svh"

module grayscale_error_diffusion_dither #(
   parameter int MAX_HEIGHT = gedd_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [gedd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gedd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [7:0]                       req_red,
   input  wire logic [7:0]                       req_green,
   input  wire logic [7:0]                       req_blue,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic      [7:0]                       rsp_gray_out,
   output logic                                  rsp_end_of_image
);

   localparam int RowW  = $clog2(MAX_HEIGHT);
   localparam int PixW  = $bits(gedd_pkg::pix_type) + RowW;
   localparam int ResW  = $bits(gedd_pkg::result_type);

   logic                  accept;
   gedd_pkg::pix_type     front_pix;
   logic [RowW-1:0]       front_row;
   logic [PixW-1:0]       q_rdata;
   gedd_pkg::pix_type     q_pix;
   logic [RowW-1:0]       q_row;
   logic                  q_empty, q_pop;
   logic                  out_full, out_push;
   gedd_pkg::result_type  out_result;
   logic [ResW-1:0]       rsp_rdata;

   assign accept = req_push && !req_full;

   gedd_front #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .ROW_W      (RowW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .pix       (front_pix),
      .pix_row   (front_row)
   );

   gedd_queue #(
      .WIDTH (PixW)
   ) u_pix_queue (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .wdata ({front_pix, front_row}),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (req_full),
      .empty (q_empty)
   );

   assign q_pix = q_rdata[PixW-1:RowW];
   assign q_row = q_rdata[RowW-1:0];

   gedd_back #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .ROW_W      (RowW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_pix      (q_pix),
      .q_row      (q_row),
      .q_pop      (q_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_result (out_result)
   );

   gedd_queue #(
      .WIDTH (ResW)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_result),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .full  (out_full),
      .empty (rsp_empty)
   );

   assign rsp_gray_out     = rsp_rdata[ResW-1:1];
   assign rsp_end_of_image = rsp_rdata[0];

   `GEDD_ASSERT_NOW(a_pop_has_item, q_pop, !q_empty, "back end popped an empty queue")
   `GEDD_ASSERT_NOW(a_push_has_room, out_push, !out_full, "result pushed into a full queue")
   `GEDD_ASSERT_NOW(a_level_aligned, !rsp_empty, rsp_gray_out[3:0] == 4'h0,
                    "result level is not a multiple of 16")
   `GEDD_ASSERT_NEXT(a_accept_reaches_queue, accept, !q_empty,
                     "transferred pixel missing from the inner queue")

endmodule

`default_nettype wire

[tb/gedd_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dither result checker
// Follows the register writes and the scan position of the dither block,
// works out the quantized level and end-of-image flag of every pixel transfer
// and compares them in order with the result transfers.
// ----------------------------------------------------------------------------
module gedd_result_checker #(
   parameter int MAX_HEIGHT = gedd_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire gedd_pkg::csr_index_type         csr_index,
   input  wire logic [gedd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_push,
   input  wire logic                            req_full,
   input  wire logic [7:0]                      req_red,
   input  wire logic [7:0]                      req_green,
   input  wire logic [7:0]                      req_blue,
   input  wire logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   input  wire logic [7:0]                      rsp_gray_out,
   input  wire logic                            rsp_end_of_image,
   output int                                   pending,
   output int                                   failures,
   output int                                   results_seen,
   output int                                   images_seen
);

   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int RING_DEPTH = 64;

   logic                         color_mode;
   logic [gedd_pkg::SIZE_W-1:0]  image_width;
   logic [10:0]                  image_height;
   logic [gedd_pkg::RESID_W-1:0] row_resid [MAX_HEIGHT];
   logic [gedd_pkg::RESID_W-1:0] upper_resid;
   logic [ROW_W-1:0]             row_pos;
   logic [gedd_pkg::COL_W-1:0]   col_pos;
   gedd_pkg::result_type         expected_ring [RING_DEPTH];
   int                           pushed_count;
   int                           popped_count;

   function automatic int unsigned clip_size(int unsigned v, int unsigned limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   task automatic dither_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      logic [gedd_pkg::LUM_W-1:0]   lum;
      logic [17:0]                  sum;
      logic [gedd_pkg::RESID_W-1:0] left;
      logic [gedd_pkg::RESID_W-1:0] up;
      logic [gedd_pkg::RESID_W-1:0] resid;
      int unsigned                  w_eff;
      int unsigned                  h_eff;
      logic                         last_row;
      logic                         last_col;
      gedd_pkg::result_type         res;
      if (color_mode) begin
         lum = gedd_pkg::LUM_WEIGHT_R * r + gedd_pkg::LUM_WEIGHT_G * g
             + gedd_pkg::LUM_WEIGHT_B * b;
      end else begin
         lum = {r, 8'h00};
      end
      left = (col_pos != 0) ? row_resid[row_pos] : '0;
      up   = (row_pos != 0) ? upper_resid : '0;
      // sum in units of 1/512
      sum = 18'(2 * lum + left + up);
      if (sum > gedd_pkg::CLAMP_Q9) sum = gedd_pkg::CLAMP_Q9;
      res.gray = {sum[16:13], 4'h0};
      resid    = sum[12:1];
      row_resid[row_pos] = resid;
      upper_resid        = resid;

      w_eff    = clip_size(image_width, gedd_pkg::MAX_WIDTH);
      h_eff    = clip_size(image_height, MAX_HEIGHT);
      last_row = (int'(row_pos) + 1 >= h_eff);
      last_col = (int'(col_pos) + 1 >= w_eff);
      res.eoi  = last_row && last_col;
      if (last_row) begin
         row_pos = '0;
         col_pos = res.eoi ? '0 : col_pos + 1'b1;
      end else begin
         row_pos = row_pos + 1'b1;
      end
      expected_ring[pushed_count % RING_DEPTH] = res;
      pushed_count++;
   endtask

   always @(posedge clock) begin : watch
      gedd_pkg::result_type want;
      if (reset) begin
         color_mode   = gedd_pkg::RESET_COLOR_MODE;
         image_width  = gedd_pkg::RESET_IMAGE_WIDTH;
         image_height = gedd_pkg::RESET_IMAGE_HEIGHT;
         upper_resid  = '0;
         row_pos      = '0;
         col_pos      = '0;
         foreach (row_resid[i]) row_resid[i] = '0;
         pushed_count = 0;
         popped_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               gedd_pkg::CSR_COLOR_MODE:   color_mode   = csr_wdata[0];
               gedd_pkg::CSR_IMAGE_WIDTH:  image_width  = csr_wdata;
               gedd_pkg::CSR_IMAGE_HEIGHT: image_height = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) dither_pixel(req_red, req_green, req_blue);
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (rsp_end_of_image) images_seen++;
            if (pushed_count == popped_count) begin
               $error("result transfer with nothing expected: gray_out %0d end_of_image %0b",
                      rsp_gray_out, rsp_end_of_image);
               failures++;
            end else begin
               want = expected_ring[popped_count % RING_DEPTH];
               popped_count++;
               if (rsp_gray_out !== want.gray) begin
                  $error("gray_out mismatch: expected %0d, actual %0d", want.gray, rsp_gray_out);
                  failures++;
               end
               if (rsp_end_of_image !== want.eoi) begin
                  $error("end_of_image mismatch: expected %0b, actual %0b",
                         want.eoi, rsp_end_of_image);
                  failures++;
               end
            end
         end
      end
      pending <= pushed_count - popped_count;
   end

endmodule

[tb/tb_grayscale_error_diffusion_dither.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grayscale dither testbench
// Feeds column-ordered pixels through the dither block in color and gray mode,
// over zero, small and oversize frame settings and resizes within an image,
// with random gaps on both channels and two long output stalls. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_grayscale_error_diffusion_dither;

   localparam int LONG_HOLD    = 120;
   localparam int DATA_W       = gedd_pkg::CSR_DATA_W;
   localparam int WRITTEN_ROWS = 40;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     csr_wr_en = 1'b0;
   gedd_pkg::csr_index_type  csr_index = gedd_pkg::CSR_COLOR_MODE;
   logic [DATA_W-1:0]        csr_wdata = '0;
   logic                     req_push  = 1'b0;
   logic                     req_full;
   logic [7:0]               req_red   = '0;
   logic [7:0]               req_green = '0;
   logic [7:0]               req_blue  = '0;
   logic                     rsp_empty;
   logic                     rsp_pop   = 1'b0;
   logic [7:0]               rsp_gray_out;
   logic                     rsp_end_of_image;

   int pending;
   int failures;
   int results_seen;
   int images_seen;
   int send_idle_pct = 28;
   int recv_idle_pct = 76;
   int stall_orders  = 0;
   int stall_served  = 0;
   int hold_left     = 0;
   int pixels_sent   = 0;

   grayscale_error_diffusion_dither dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_gray_out     (rsp_gray_out),
      .rsp_end_of_image (rsp_end_of_image)
   );

   gedd_result_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_gray_out     (rsp_gray_out),
      .rsp_end_of_image (rsp_end_of_image),
      .pending          (pending),
      .failures         (failures),
      .results_seen     (results_seen),
      .images_seen      (images_seen)
   );

   always #5 clock = ~clock;

   // receiver: random pops, long hold when ordered
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_served != stall_orders) begin
         stall_served <= stall_orders;
         hold_left    <= LONG_HOLD;
         rsp_pop      <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [7:0] pick_sample();
      case ($urandom_range(3))
         0:       return $urandom_range(1) ? 8'hFF : 8'h00;
         1:       return 8'($urandom_range(15) * 16 - $urandom_range(1));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_size(int unsigned biggest, int unsigned usual);
      case ($urandom_range(19))
         0:       return '0;
         1:       return DATA_W'($urandom_range(biggest));
         default: return DATA_W'($urandom_range(1, usual));
      endcase
   endfunction

   task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      req_push  <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pixels_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic settle();
      req_push <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic apply_config(input logic color, input logic [DATA_W-1:0] width,
                               input logic [DATA_W-1:0] height);
      csr_wr_en <= 1'b1;
      csr_index <= gedd_pkg::CSR_COLOR_MODE;
      csr_wdata <= DATA_W'(color);
      @(posedge clock);
      csr_index <= gedd_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= width;
      @(posedge clock);
      csr_index <= gedd_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= height;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_burst(input int count);
      repeat (count) push_pixel(pick_sample(), pick_sample(), pick_sample());
      settle();
   endtask

   initial begin
      int random_sent;
      int burst;
      random_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // top of a column at reset size, color mode
      push_pixel(8'd0, 8'd0, 8'd0);
      push_pixel(8'd255, 8'd255, 8'd255);
      push_pixel(8'd255, 8'd0, 8'd0);
      push_pixel(8'd0, 8'd255, 8'd0);
      settle();

      // shrink mid-column: next pixel ends the column, second column ends the image
      apply_config(1'b1, 13'd2, 13'd2);
      push_pixel(8'd0, 8'd0, 8'd255);
      push_pixel(8'd128, 8'd128, 8'd128);
      push_pixel(8'd255, 8'd255, 8'd255);
      settle();

      // zero sizes act as one pixel per image, gray mode
      apply_config(1'b0, 13'd0, 13'd0);
      push_pixel(8'd255, 8'($urandom), 8'($urandom));
      push_pixel(8'd0, 8'($urandom), 8'($urandom));
      push_pixel(8'd15, 8'($urandom), 8'($urandom));
      push_pixel(8'd16, 8'($urandom), 8'($urandom));
      push_pixel(8'd239, 8'($urandom), 8'($urandom));
      push_pixel(8'd240, 8'($urandom), 8'($urandom));
      settle();

      apply_config(1'b1, 13'd3, 13'd3);
      send_burst(9);

      // oversize height: one tall column writes every row used later
      apply_config(1'b1, 13'd1, 13'd2047);
      stall_orders <= stall_orders + 1;
      send_burst(WRITTEN_ROWS);

      // oversize width, one row
      apply_config(1'b0, 13'd8191, 13'd1);
      send_burst(24);

      while (random_sent < 360) begin
         if (random_sent >= 240 && send_idle_pct != 0) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            stall_orders <= stall_orders + 1;
         end else if (random_sent >= 120 && recv_idle_pct == 76) begin
            send_idle_pct = 76;
            recv_idle_pct = 28;
         end
         burst = $urandom_range(1, 40);
         apply_config(1'($urandom_range(1)), pick_size(8191, 6), pick_size(WRITTEN_ROWS, 8));
         send_burst(burst);
         random_sent += burst;
      end

      repeat (8) @(posedge clock);
      $display("%0d pixel transfers, %0d results checked, %0d complete images;",
               pixels_sent, results_seen, images_seen);
      $display("color and gray mode, zero to oversize frames, mid-image resizes, output stall.");
      if (failures == 0 && pending == 0) begin
         $display("** grayscale_error_diffusion_dither: PASSED **");
      end else begin
         $display("** grayscale_error_diffusion_dither: FAILED **");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("** grayscale_error_diffusion_dither: FAILED **");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/gedd_pkg.sv
design/gedd_queue.sv
design/gedd_front.sv
design/gedd_back.sv
design/grayscale_error_diffusion_dither.sv
tb/gedd_result_checker.sv
tb/tb_grayscale_error_diffusion_dither.sv
